// ----- rtl/tmst_pkg.sv -----
// tagged message slot table: shared package
// command and status codes, word types and the tag lfsr step
// depends on nothing
package tmst_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [3:0] CMD_ALLOC    = 4'd0;
    localparam logic [3:0] CMD_COMMIT   = 4'd1;
    localparam logic [3:0] CMD_FREE     = 4'd2;
    localparam logic [3:0] CMD_SET_SENT = 4'd3;
    localparam logic [3:0] CMD_OLDEST   = 4'd4;
    localparam logic [3:0] CMD_BY_ID    = 4'd5;
    localparam logic [3:0] CMD_SENT_TAG = 4'd6;
    localparam logic [3:0] CMD_TICK     = 4'd7;
    localparam logic [3:0] CMD_READ_ID  = 4'd8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EXISTS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [30:0] LFSR_SEED = 31'h2A5A5A5A;

    typedef struct packed {
        logic [3:0]  command;
        logic [30:0] tag;
        logic        overwrite;
        logic [15:0] lifetime;
        logic        no_age;
        logic [3:0]  slot;
        logic [31:0] uid;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_out;
        logic [31:0] uid_out;
        logic [30:0] tag_out;
        logic [4:0]  used_count;
    } t_res;

    function automatic logic [30:0] lfsr_next(input logic [30:0] s);
        return {s[29:0], s[30] ^ s[27]};
    endfunction

endpackage

// ----- rtl/tmst_chan_if.sv -----
// tagged message slot table: valid/ready channel carrying one word
// payload type given by parameter, types from tmst_pkg
// depends on nothing
interface tmst_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tagged_message_slot_table.sv -----
// tagged message slot table: top level, sequencer over a one-slot-per-cycle scan
// depends on tmst_pkg, tmst_chan_if, tmst_mem
//
// channel | dir | word  | handshake
// i_cmd   | in  | t_cmd | valid/ready
// o_res   | out | t_res | valid/ready
//
// commit, free, set sent, read id: S_SGL, S_SGL2, S_DONE; full generated alloc: S_DONE at once
// scans (oldest, by id, sent by tag, tick) and refused alloc with tag: S_SCAN, S_EVAL, S_DONE
// granted alloc with tag: S_SCAN, S_EVAL, S_ALLOC_WR, S_DONE; unknown command: S_DONE at once
// alloc with generated tag: up to SLOTS + 1 tries, one scan per lfsr try
// every scan walks the slot store one entry a cycle through its single read port
// i_rst_n clears all slot flags and the used and id counters and loads the lfsr seed; store contents need no reset
// a result waits in the output register; the next command is taken meanwhile
module tagged_message_slot_table #(
    parameter int SLOTS = tmst_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmst_chan_if.sink   i_cmd,
    tmst_chan_if.source o_res
);
    import tmst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SGL      = 3'd1;
    localparam logic [2:0] S_SGL2     = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_EVAL     = 3'd4;
    localparam logic [2:0] S_ALLOC_WR = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]       r_state;
    t_cmd             r_cmd;
    logic [SLOTS-1:0] r_alloc, r_comm, r_sent, r_noage;
    logic [31:0]      r_last;
    logic [CW-1:0]    r_used;
    logic [30:0]      r_lfsr;
    logic [30:0]      r_stag;
    logic [CW-1:0]    r_try;
    logic [CW-1:0]    r_idx;
    logic [IW-1:0]    r_pidx;
    logic             r_pv;
    logic             r_hit;
    logic [IW-1:0]    r_hidx;
    logic [31:0]      r_huid;
    logic [30:0]      r_htag;
    logic             r_fok;
    logic [IW-1:0]    r_fidx;
    logic [1:0]       r_rst;
    logic             r_rv;
    logic [IW-1:0]    r_ridx;
    logic [31:0]      r_ruid;
    logic [30:0]      r_rtag;
    t_res             r_res;
    logic             r_ovalid;

    logic [31:0]      m_uid;
    logic [30:0]      m_tag;
    logic [15:0]      m_life;
    logic [IW-1:0]    sidx;
    logic             s_live;
    logic             p_a, p_c, p_s, p_na;
    logic             p_last;
    logic             we_all, we_life;
    logic [IW-1:0]    waddr, raddr;
    logic [15:0]      wlife;
    logic [30:0]      n_lfsr;

    assign sidx   = IW'(r_cmd.slot);
    assign s_live = ({28'd0, r_cmd.slot} < 32'(SLOTS)) && r_alloc[sidx];
    assign p_a    = r_alloc[r_pidx];
    assign p_c    = r_comm[r_pidx];
    assign p_s    = r_sent[r_pidx];
    assign p_na   = r_noage[r_pidx];
    assign p_last = r_pv && (r_pidx == IW'(SLOTS - 1));
    assign n_lfsr = lfsr_next(r_lfsr);

    assign we_all  = (r_state == S_ALLOC_WR);
    assign we_life = (r_state == S_SCAN) && r_pv && (r_cmd.command == CMD_TICK)
                     && p_a && !p_na && (m_life != 16'd0);
    assign waddr   = we_all ? r_fidx : r_pidx;
    assign wlife   = we_all ? r_cmd.lifetime : m_life - 16'd1;
    assign raddr   = (r_state == S_SCAN) ? r_idx[IW-1:0] : sidx;

    tmst_mem #(.SLOTS(SLOTS)) u_mem (
        .i_clk     (i_clk),
        .i_we_all  (we_all),
        .i_we_life (we_life),
        .i_waddr   (waddr),
        .i_wuid    (r_last + 32'd1),
        .i_wtag    (r_stag),
        .i_wlife   (wlife),
        .i_raddr   (raddr),
        .o_ruid    (m_uid),
        .o_rtag    (m_tag),
        .o_rlife   (m_life)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_alloc  <= '0;
            r_comm   <= '0;
            r_sent   <= '0;
            r_noage  <= '0;
            r_last   <= '0;
            r_used   <= '0;
            r_lfsr   <= LFSR_SEED;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            if (r_ovalid && o_res.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd  <= i_cmd.data;
                        r_idx  <= '0;
                        r_hit  <= 1'b0;
                        r_fok  <= 1'b0;
                        r_try  <= '0;
                        r_rv   <= 1'b0;
                        unique case (i_cmd.data.command)
                            CMD_ALLOC: begin
                                if (i_cmd.data.tag == 31'd0) begin
                                    if (r_used >= CW'(SLOTS)) begin
                                        r_rst   <= ST_FULL;
                                        r_stag  <= i_cmd.data.tag;
                                        r_state <= S_DONE;
                                    end else begin
                                        r_rst   <= ST_OK;
                                        r_lfsr  <= n_lfsr;
                                        r_stag  <= n_lfsr;
                                        r_state <= S_SCAN;
                                    end
                                end else begin
                                    r_rst   <= ST_OK;
                                    r_stag  <= i_cmd.data.tag;
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_COMMIT, CMD_FREE, CMD_SET_SENT, CMD_READ_ID: begin
                                r_rst   <= ST_OK;
                                r_stag  <= i_cmd.data.tag;
                                r_state <= S_SGL;
                            end
                            CMD_OLDEST, CMD_BY_ID, CMD_SENT_TAG, CMD_TICK: begin
                                r_rst   <= ST_OK;
                                r_stag  <= i_cmd.data.tag;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_rst   <= ST_NOTFOUND;
                                r_stag  <= i_cmd.data.tag;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SGL: begin
                    r_state <= S_SGL2;
                end
                S_SGL2: begin
                    if (!s_live) begin
                        r_rst <= ST_NOTFOUND;
                    end else begin
                        r_rv   <= 1'b1;
                        r_ridx <= sidx;
                        r_ruid <= m_uid;
                        r_rtag <= m_tag;
                        if (r_cmd.command == CMD_COMMIT) begin
                            r_comm[sidx] <= 1'b1;
                        end
                        if (r_cmd.command == CMD_SET_SENT) begin
                            r_sent[sidx] <= 1'b1;
                        end
                        if (r_cmd.command == CMD_FREE) begin
                            r_alloc[sidx] <= 1'b0;
                            r_comm[sidx]  <= 1'b0;
                            r_used        <= r_used - CW'(1);
                        end
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    r_pv <= (r_idx < CW'(SLOTS));
                    if (r_idx < CW'(SLOTS)) begin
                        r_pidx <= r_idx[IW-1:0];
                        r_idx  <= r_idx + CW'(1);
                    end
                    if (r_pv) begin
                        unique case (r_cmd.command)
                            CMD_ALLOC: begin
                                if (p_a && (m_tag == r_stag) && !r_hit) begin
                                    r_hit  <= 1'b1;
                                    r_hidx <= r_pidx;
                                end
                                if (!p_a && !r_fok) begin
                                    r_fok  <= 1'b1;
                                    r_fidx <= r_pidx;
                                end
                            end
                            CMD_OLDEST: begin
                                if (p_a && p_c && (!r_hit || (m_uid < r_huid))) begin
                                    r_hit  <= 1'b1;
                                    r_hidx <= r_pidx;
                                    r_huid <= m_uid;
                                    r_htag <= m_tag;
                                end
                            end
                            CMD_BY_ID: begin
                                if (p_a && p_c && (m_uid == r_cmd.uid) && !r_hit) begin
                                    r_hit  <= 1'b1;
                                    r_hidx <= r_pidx;
                                    r_huid <= m_uid;
                                    r_htag <= m_tag;
                                end
                            end
                            CMD_SENT_TAG: begin
                                if (p_a && p_c && p_s && (m_tag == r_cmd.tag) && !r_hit) begin
                                    r_hit  <= 1'b1;
                                    r_hidx <= r_pidx;
                                    r_huid <= m_uid;
                                    r_htag <= m_tag;
                                end
                            end
                            CMD_TICK: begin
                                if (p_a && !p_na && (m_life == 16'd0)) begin
                                    r_alloc[r_pidx] <= 1'b0;
                                    r_comm[r_pidx]  <= 1'b0;
                                    r_used          <= r_used - CW'(1);
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (p_last) begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    unique case (r_cmd.command)
                        CMD_ALLOC: begin
                            if (r_cmd.tag == 31'd0) begin
                                if (!r_hit) begin
                                    if (r_fok) begin
                                        r_state <= S_ALLOC_WR;
                                    end else begin
                                        r_rst   <= ST_FULL;
                                        r_state <= S_DONE;
                                    end
                                end else if (r_try == CW'(SLOTS)) begin
                                    r_rst   <= ST_FULL;
                                    r_state <= S_DONE;
                                end else begin
                                    r_try   <= r_try + CW'(1);
                                    r_lfsr  <= n_lfsr;
                                    r_stag  <= n_lfsr;
                                    r_idx   <= '0;
                                    r_hit   <= 1'b0;
                                    r_fok   <= 1'b0;
                                    r_state <= S_SCAN;
                                end
                            end else if ((r_used >= CW'(SLOTS)) && !(r_cmd.overwrite && r_hit)) begin
                                r_rst   <= ST_FULL;
                                r_state <= S_DONE;
                            end else if (r_hit && !r_cmd.overwrite) begin
                                r_rst   <= ST_EXISTS;
                                r_state <= S_DONE;
                            end else if (r_hit) begin
                                r_alloc[r_hidx] <= 1'b0;
                                r_comm[r_hidx]  <= 1'b0;
                                r_used          <= r_used - CW'(1);
                                r_fok           <= 1'b1;
                                if (!r_fok || (r_hidx < r_fidx)) begin
                                    r_fidx <= r_hidx;
                                end
                                r_state <= S_ALLOC_WR;
                            end else if (r_fok) begin
                                r_state <= S_ALLOC_WR;
                            end else begin
                                r_rst   <= ST_FULL;
                                r_state <= S_DONE;
                            end
                        end
                        CMD_OLDEST, CMD_BY_ID, CMD_SENT_TAG: begin
                            if (r_hit) begin
                                r_rv   <= 1'b1;
                                r_ridx <= r_hidx;
                                r_ruid <= r_huid;
                                r_rtag <= r_htag;
                            end else begin
                                r_rst <= ST_NOTFOUND;
                            end
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_ALLOC_WR: begin
                    r_alloc[r_fidx] <= 1'b1;
                    r_comm[r_fidx]  <= 1'b0;
                    r_sent[r_fidx]  <= 1'b0;
                    r_noage[r_fidx] <= r_cmd.no_age;
                    r_last          <= r_last + 32'd1;
                    r_used          <= r_used + CW'(1);
                    r_rv            <= 1'b1;
                    r_ridx          <= r_fidx;
                    r_ruid          <= r_last + 32'd1;
                    r_rtag          <= r_stag;
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_res.status     <= r_rst;
                        r_res.slot_out   <= r_rv ? 4'(r_ridx) : 4'd0;
                        r_res.uid_out    <= r_rv ? r_ruid : 32'd0;
                        r_res.tag_out    <= r_rv ? r_rtag : 31'd0;
                        r_res.used_count <= 5'(r_used);
                        r_ovalid         <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(SLOTS))
        else $error("used count above slot count");

    a_used_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_alloc) == int'(r_used))
        else $error("used count disagrees with allocated flags");

    a_comm_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_comm & ~r_alloc) == '0)
        else $error("committed slot not allocated");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state != S_IDLE))
        else $error("sequencer idle right after taking a word");
`endif

endmodule

// ----- rtl/tmst_mem.sv -----
// tagged message slot table: per-slot id, tag and lifetime store
// one write port, one registered read port
// depends on tmst_pkg
module tmst_mem #(
    parameter int SLOTS = tmst_pkg::SLOTS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_we_all,
    input  logic                                    i_we_life,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_waddr,
    input  logic [31:0]                             i_wuid,
    input  logic [30:0]                             i_wtag,
    input  logic [15:0]                             i_wlife,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_raddr,
    output logic [31:0]                             o_ruid,
    output logic [30:0]                             o_rtag,
    output logic [15:0]                             o_rlife
);
    import tmst_pkg::*;

    logic [31:0] r_uid_mem  [SLOTS];
    logic [30:0] r_tag_mem  [SLOTS];
    logic [15:0] r_life_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we_all) begin
            r_uid_mem[i_waddr] <= i_wuid;
            r_tag_mem[i_waddr] <= i_wtag;
        end
        if (i_we_all || i_we_life) begin
            r_life_mem[i_waddr] <= i_wlife;
        end
        o_ruid  <= r_uid_mem[i_raddr];
        o_rtag  <= r_tag_mem[i_raddr];
        o_rlife <= r_life_mem[i_raddr];
    end

endmodule
